// File: rtl/ppcd_pkg.sv
// Shared types, widths and constants for the pressure pad click detector.
package ppcd_pkg;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned ELAPSED_W   = 8;
    localparam int unsigned MS_W        = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned DELAY_W     = 3;

    localparam int unsigned WINDOW_LENGTH_DEF = 3;
    localparam int unsigned TIME_BITS_DEF     = 16;

    // delay counter: click shows once past DELAY_FIRE, count tops out at DELAY_TOP
    localparam logic [DELAY_W-1:0] DELAY_FIRE = 3'd2;
    localparam logic [DELAY_W-1:0] DELAY_TOP  = 3'd3;

    localparam logic [SAMPLE_W-1:0] PRESS_LEVEL_RST   = 12'd600;
    localparam logic [SAMPLE_W-1:0] RELEASE_LEVEL_RST = 12'd200;
    localparam logic [MS_W-1:0]     FIRST_WINDOW_RST  = 16'd30;
    localparam logic [MS_W-1:0]     SECOND_WINDOW_RST = 16'd200;
    localparam logic [MS_W-1:0]     HOLD_LIMIT_RST    = 16'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEFT_PRESS    = 3'd0,
        REG_LEFT_RELEASE  = 3'd1,
        REG_RIGHT_PRESS   = 3'd2,
        REG_RIGHT_RELEASE = 3'd3,
        REG_FIRST_WINDOW  = 3'd4,
        REG_SECOND_WINDOW = 3'd5,
        REG_HOLD_LIMIT    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  left_sample;
        logic [SAMPLE_W-1:0]  right_sample;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic left_click;
        logic right_click;
        logic send_enable;
        logic first_gesture_led;
        logic toggle_led;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_press_level;
        logic [SAMPLE_W-1:0] left_release_level;
        logic [SAMPLE_W-1:0] right_press_level;
        logic [SAMPLE_W-1:0] right_release_level;
        logic [MS_W-1:0]     first_window_ms;
        logic [MS_W-1:0]     second_window_ms;
        logic [MS_W-1:0]     hold_limit_ms;
    } ppcd_cfg_t;

endpackage

// File: rtl/pressure_pad_click_detector_top.sv
// Top level of the pressure pad click detector: registers, config and pipeline control.
//
//   channel   signals                              dir   beat
//   in        in_valid, in_ready, in_data          in    two pad samples + elapsed ms
//   out       out_valid, out_ready, out_data       out   clicks, send flag, leds
//   cfg       cfg_we, cfg_index, cfg_wdata         in    one register write per cycle
//
// One beat per cycle sustained while out_ready stays high; out_valid is registered.
// Input register -> averaging and control logic -> output register; the state
// updates when a beat moves from the input register to the output register.
// Reset loads the register defaults and clears all state; the send flag resets set.
// A stalled output holds its beat; the input register still takes a beat while
// the output one waits, then stalls until the output drains.
module pressure_pad_click_detector_top
    import ppcd_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int unsigned TIME_BITS     = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    ppcd_cfg_t           cfg_reg;
    in_item_t            in_reg;
    logic                s1_valid_reg;
    out_item_t           out_reg;
    logic                out_valid_reg;
    logic                s1_adv;
    logic [SAMPLE_W-1:0] left_avg;
    logic [SAMPLE_W-1:0] right_avg;
    out_item_t           result;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_press_level    <= PRESS_LEVEL_RST;
            cfg_reg.left_release_level  <= RELEASE_LEVEL_RST;
            cfg_reg.right_press_level   <= PRESS_LEVEL_RST;
            cfg_reg.right_release_level <= RELEASE_LEVEL_RST;
            cfg_reg.first_window_ms     <= FIRST_WINDOW_RST;
            cfg_reg.second_window_ms    <= SECOND_WINDOW_RST;
            cfg_reg.hold_limit_ms       <= HOLD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT_PRESS:    cfg_reg.left_press_level    <= cfg_wdata[SAMPLE_W-1:0];
                REG_LEFT_RELEASE:  cfg_reg.left_release_level  <= cfg_wdata[SAMPLE_W-1:0];
                REG_RIGHT_PRESS:   cfg_reg.right_press_level   <= cfg_wdata[SAMPLE_W-1:0];
                REG_RIGHT_RELEASE: cfg_reg.right_release_level <= cfg_wdata[SAMPLE_W-1:0];
                REG_FIRST_WINDOW:  cfg_reg.first_window_ms     <= cfg_wdata[MS_W-1:0];
                REG_SECOND_WINDOW: cfg_reg.second_window_ms    <= cfg_wdata[MS_W-1:0];
                REG_HOLD_LIMIT:    cfg_reg.hold_limit_ms       <= cfg_wdata[MS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_reg <= result;
        end
    end

    ppcd_avg #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_left_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .sample  (in_reg.left_sample),
        .avg     (left_avg)
    );

    ppcd_avg #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_right_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .sample  (in_reg.right_sample),
        .avg     (right_avg)
    );

    ppcd_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_adv),
        .cfg        (cfg_reg),
        .left_avg   (left_avg),
        .right_avg  (right_avg),
        .elapsed_ms (in_reg.elapsed_ms),
        .result     (result)
    );

    // a beat held in the input register with the output free must move on
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input register beat did not reach output");

    // an empty input register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("in_ready low with empty input register");

    // output only becomes valid from a beat leaving the input register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv))
        else $error("output valid without a beat from the input register");

endmodule

// File: rtl/ppcd_avg.sv
// Moving average of one pad: sample window, running sum, divide by window length.
module ppcd_avg
    import ppcd_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [SAMPLE_W-1:0] avg
);

    localparam int unsigned SUM_W     = $clog2(WINDOW_LENGTH * (2 ** SAMPLE_W - 1) + 1);
    localparam int unsigned SLOT_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int unsigned MULT_W    = SUM_W + 1;
    localparam int unsigned PROD_W    = SUM_W + MULT_W;
    // reciprocal, rounded up; exact for every sum below 2**SUM_W
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'((2 ** DIV_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LENGTH - 1);

    logic [SAMPLE_W-1:0] window_reg [WINDOW_LENGTH];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   product;

    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(window_reg[slot_reg]) + SUM_W'(sample);
        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        product   = PROD_W'(sum_next) * PROD_W'(DIV_MULT);
    end

    assign avg = product[DIV_SHIFT +: SAMPLE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
        end
        else if (advance)
        begin
            window_reg[slot_reg] <= sample;
            slot_reg             <= slot_next;
            sum_reg              <= sum_next;
        end
    end

endmodule

// File: rtl/ppcd_ctrl.sv
// Hysteresis, click delay, double-hold and gesture window control.
module ppcd_ctrl
    import ppcd_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  ppcd_cfg_t            cfg,
    input  logic [SAMPLE_W-1:0]  left_avg,
    input  logic [SAMPLE_W-1:0]  right_avg,
    input  logic [ELAPSED_W-1:0] elapsed_ms,
    output out_item_t            result
);

    localparam int unsigned CMP_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [ELAPSED_W-1:0] b
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    logic l_latched_reg, l_latched_next, r_latched_reg, r_latched_next;
    logic l_held_reg, l_held_next, r_held_reg, r_held_next;
    logic l_dly_act_reg, l_dly_act_next, r_dly_act_reg, r_dly_act_next;
    logic [DELAY_W-1:0] l_dly_cnt_reg, l_dly_cnt_next, r_dly_cnt_reg, r_dly_cnt_next;
    logic hold_cand_reg, hold_cand_next, hold_forced_reg, hold_forced_next;
    logic [TIME_BITS-1:0] hold_time_reg, hold_time_next;
    logic fw_run_reg, fw_run_next, sw_run_reg, sw_run_next;
    logic [TIME_BITS-1:0] fw_time_reg, fw_time_next, sw_time_reg, sw_time_next;
    logic first_pair_reg, first_pair_next, second_pair_reg, second_pair_next;
    logic toggle_done_reg, toggle_done_next, sending_reg, sending_next;
    logic first_led_reg, first_led_next, toggle_led_reg, toggle_led_next;

    always_comb
    begin
        l_latched_next   = l_latched_reg;
        r_latched_next   = r_latched_reg;
        l_held_next      = l_held_reg;
        r_held_next      = r_held_reg;
        l_dly_act_next   = l_dly_act_reg;
        r_dly_act_next   = r_dly_act_reg;
        l_dly_cnt_next   = l_dly_cnt_reg;
        r_dly_cnt_next   = r_dly_cnt_reg;
        hold_cand_next   = hold_cand_reg;
        hold_forced_next = hold_forced_reg;
        hold_time_next   = hold_time_reg;
        fw_run_next      = fw_run_reg;
        sw_run_next      = sw_run_reg;
        fw_time_next     = fw_time_reg;
        sw_time_next     = sw_time_reg;
        first_pair_next  = first_pair_reg;
        second_pair_next = second_pair_reg;
        toggle_done_next = toggle_done_reg;
        sending_next     = sending_reg;
        first_led_next   = first_led_reg;
        toggle_led_next  = toggle_led_reg;

        // clicks come from the state held before this beat
        result.left_click  = ((l_dly_cnt_reg > DELAY_FIRE) && l_dly_act_reg) || hold_forced_reg;
        result.right_click = ((r_dly_cnt_reg > DELAY_FIRE) && r_dly_act_reg) || hold_forced_reg;
        result.send_enable = sending_reg;

        // hysteresis
        if ((left_avg > cfg.left_press_level) && !l_latched_reg)
        begin
            fw_run_next    = 1'b1;
            l_dly_act_next = 1'b1;
            l_held_next    = 1'b1;
            l_latched_next = 1'b1;
        end
        else if (left_avg < cfg.left_release_level)
        begin
            l_latched_next = 1'b0;
            l_held_next    = 1'b0;
        end
        if ((right_avg > cfg.right_press_level) && !r_latched_reg)
        begin
            r_dly_act_next = 1'b1;
            r_held_next    = 1'b1;
            r_latched_next = 1'b1;
        end
        else if (right_avg < cfg.right_release_level)
        begin
            r_latched_next = 1'b0;
            r_held_next    = 1'b0;
        end

        // double hold
        if (hold_cand_reg && r_held_next && l_held_next)
        begin
            hold_time_next = sat_add(hold_time_reg, elapsed_ms);
        end
        if (!r_held_next || !l_held_next)
        begin
            hold_cand_next   = 1'b0;
            hold_forced_next = 1'b0;
            hold_time_next   = '0;
        end
        if (CMP_W'(hold_time_next) > CMP_W'(cfg.hold_limit_ms))
        begin
            hold_forced_next = 1'b1;
        end

        // delay counters
        if (l_dly_act_next)
        begin
            l_dly_cnt_next = l_dly_cnt_reg + 1'b1;
        end
        if (l_dly_cnt_next > DELAY_TOP)
        begin
            if (!l_held_next)
            begin
                l_dly_act_next = 1'b0;
                l_dly_cnt_next = '0;
            end
            else
            begin
                l_dly_cnt_next = DELAY_TOP;
            end
        end
        if (r_dly_act_next)
        begin
            r_dly_cnt_next = r_dly_cnt_reg + 1'b1;
        end
        if (r_dly_cnt_next > DELAY_TOP)
        begin
            r_dly_act_next = 1'b0;
            r_dly_cnt_next = '0;
        end

        // gesture windows
        if (fw_run_next)
        begin
            fw_time_next = sat_add(fw_time_reg, elapsed_ms);
        end
        if (sw_run_next)
        begin
            sw_time_next = sat_add(sw_time_reg, elapsed_ms);
        end
        if ((fw_time_next != '0) && (sw_time_next != '0) && first_pair_reg
            && (r_dly_cnt_next != '0))
        begin
            second_pair_next = 1'b1;
        end
        if ((fw_time_next != '0) && (r_dly_cnt_next != '0))
        begin
            first_pair_next = 1'b1;
            first_led_next  = 1'b1;
        end
        if (first_pair_next || second_pair_next)
        begin
            l_dly_act_next = 1'b0;
            l_dly_cnt_next = '0;
            r_dly_act_next = 1'b0;
            r_dly_cnt_next = '0;
            hold_cand_next = 1'b1;
        end
        if (second_pair_next && !toggle_done_reg)
        begin
            toggle_led_next  = 1'b1;
            toggle_done_next = 1'b1;
            sending_next     = !sending_reg;
        end
        if (CMP_W'(fw_time_next) > CMP_W'(cfg.first_window_ms))
        begin
            fw_run_next    = 1'b0;
            sw_run_next    = 1'b1;
            fw_time_next   = '0;
            first_led_next = 1'b0;
        end
        if (CMP_W'(sw_time_next) >= CMP_W'(cfg.second_window_ms))
        begin
            sw_run_next      = 1'b0;
            sw_time_next     = '0;
            first_pair_next  = 1'b0;
            second_pair_next = 1'b0;
            toggle_done_next = 1'b0;
            toggle_led_next  = 1'b0;
        end

        result.first_gesture_led = first_led_next;
        result.toggle_led        = toggle_led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_latched_reg   <= 1'b0;
            r_latched_reg   <= 1'b0;
            l_held_reg      <= 1'b0;
            r_held_reg      <= 1'b0;
            l_dly_act_reg   <= 1'b0;
            r_dly_act_reg   <= 1'b0;
            l_dly_cnt_reg   <= '0;
            r_dly_cnt_reg   <= '0;
            hold_cand_reg   <= 1'b0;
            hold_forced_reg <= 1'b0;
            hold_time_reg   <= '0;
            fw_run_reg      <= 1'b0;
            sw_run_reg      <= 1'b0;
            fw_time_reg     <= '0;
            sw_time_reg     <= '0;
            first_pair_reg  <= 1'b0;
            second_pair_reg <= 1'b0;
            toggle_done_reg <= 1'b0;
            sending_reg     <= 1'b1;
            first_led_reg   <= 1'b0;
            toggle_led_reg  <= 1'b0;
        end
        else if (advance)
        begin
            l_latched_reg   <= l_latched_next;
            r_latched_reg   <= r_latched_next;
            l_held_reg      <= l_held_next;
            r_held_reg      <= r_held_next;
            l_dly_act_reg   <= l_dly_act_next;
            r_dly_act_reg   <= r_dly_act_next;
            l_dly_cnt_reg   <= l_dly_cnt_next;
            r_dly_cnt_reg   <= r_dly_cnt_next;
            hold_cand_reg   <= hold_cand_next;
            hold_forced_reg <= hold_forced_next;
            hold_time_reg   <= hold_time_next;
            fw_run_reg      <= fw_run_next;
            sw_run_reg      <= sw_run_next;
            fw_time_reg     <= fw_time_next;
            sw_time_reg     <= sw_time_next;
            first_pair_reg  <= first_pair_next;
            second_pair_reg <= second_pair_next;
            toggle_done_reg <= toggle_done_next;
            sending_reg     <= sending_next;
            first_led_reg   <= first_led_next;
            toggle_led_reg  <= toggle_led_next;
        end
    end

endmodule
